// File: src/ihl_pkg.sv
`timescale 1ns / 1ps

package ihl_pkg;

    // Width of the memory write address.
    localparam int ADDR_W = 16;
    // Configuration registers are all this wide.
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BIAS = 2'd2;

    localparam logic [CFG_W-1:0] MEM_SIZE_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_CHAR    = 2'd0,
        ACT_EOL     = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    // Character positions: colon, count digits, address digits, type digits.
    localparam logic [POS_W-1:0] POS_COUNT_LAST = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST  = 10'd6;
    localparam logic [POS_W-1:0] POS_KIND_LAST  = 10'd8;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 10'd9;

    typedef struct packed {
        logic [CFG_W-1:0] mem_base;
        logic [CFG_W-1:0] mem_size;
        logic [CFG_W-1:0] addr_bias;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_data;
        logic [1:0]        line_status;
        logic              stopped;
    } t_result;

endpackage

// File: src/ihl_in_if.sv
`timescale 1ns / 1ps

interface ihl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink (input valid, input action, input char_code, output ready);
endinterface

// File: src/ihl_out_if.sv
`timescale 1ns / 1ps

interface ihl_out_if;
    logic                      valid;
    logic                      ready;
    logic                      write_valid;
    logic [ihl_pkg::ADDR_W-1:0] write_addr;
    logic [7:0]                write_data;
    logic [1:0]                line_status;
    logic                      stopped;

    modport source (
        output valid, output write_valid, output write_addr, output write_data,
        output line_status, output stopped, input ready
    );
    modport sink (
        input valid, input write_valid, input write_addr, input write_data,
        input line_status, input stopped, output ready
    );
endinterface

// File: src/ihl_cfg.sv
`timescale 1ns / 1ps

module ihl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [ihl_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [ihl_pkg::CFG_W-1:0]     i_data,
    output ihl_pkg::t_cfg                 o_cfg
);
    import ihl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mem_base  <= '0;
            r_cfg.mem_size  <= MEM_SIZE_RESET;
            r_cfg.addr_bias <= '0;
        end else if (i_we) begin
            // Writes to an index past the list are dropped.
            unique case (i_idx)
                CFG_MEM_BASE:  r_cfg.mem_base  <= i_data;
                CFG_MEM_SIZE:  r_cfg.mem_size  <= i_data;
                CFG_ADDR_BIAS: r_cfg.addr_bias <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/ihl_parser.sv
`timescale 1ns / 1ps

module ihl_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ihl_pkg::t_in_item i_item,
    input  ihl_pkg::t_cfg     i_cfg,
    output ihl_pkg::t_result  o_result
);
    import ihl_pkg::*;

    logic [POS_W-1:0] r_pos,     n_pos;
    logic [7:0]       r_count,   n_count;
    logic [16:0]      r_addr,    n_addr;
    logic [7:0]       r_kind,    n_kind;
    logic [3:0]       r_high,    n_high;
    logic [7:0]       r_index,   n_index;
    logic [1:0]       r_outcome, n_outcome;
    logic             r_halted,  n_halted;

    logic       dig_ok;
    logic [3:0] dig_val;
    logic [7:0] ch;
    logic [15:0] addr_shift;
    logic [17:0] addr_end;
    logic [1:0]  eol_res;
    t_result     res;

    assign ch = i_item.char_code;

    always_comb begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            dig_val = 4'(ch - CHAR_ZERO);
        end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
            dig_val = 4'(ch - CHAR_UA + 8'd10);
        end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
            dig_val = 4'(ch - CHAR_LA + 8'd10);
        end else begin
            dig_ok = 1'b0;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_count   = r_count;
        n_addr    = r_addr;
        n_kind    = r_kind;
        n_high    = r_high;
        n_index   = r_index;
        n_outcome = r_outcome;
        n_halted  = r_halted;
        res       = '0;
        eol_res   = r_outcome;
        addr_shift = {r_addr[11:0], dig_val};
        // The overflow sum uses the address that was finished at its last digit.
        addr_end  = {1'b0, r_addr} + {10'd0, r_count};

        unique case (t_action'(i_item.action))
            ACT_RESTART: begin
                n_pos     = '0;
                n_count   = '0;
                n_addr    = '0;
                n_kind    = '0;
                n_high    = '0;
                n_index   = '0;
                n_outcome = ST_NONE;
                n_halted  = 1'b0;
            end
            ACT_EOL: begin
                if (!r_halted) begin
                    if (eol_res == ST_NONE) begin
                        if (r_pos < POS_DATA_FIRST) begin
                            eol_res = ST_INVALID;
                        end else if (r_kind == 8'd0 && r_index < r_count) begin
                            eol_res = ST_INVALID;
                        end
                    end
                    if (eol_res == ST_NONE) begin
                        res.line_status = ST_OK;
                    end else begin
                        res.line_status = eol_res;
                        n_halted = 1'b1;
                    end
                end
                n_pos     = '0;
                n_count   = '0;
                n_addr    = '0;
                n_kind    = '0;
                n_high    = '0;
                n_index   = '0;
                n_outcome = ST_NONE;
            end
            ACT_CHAR: begin
                if (!r_halted && r_outcome == ST_NONE) begin
                    if (r_pos == '0) begin
                        if (ch != CHAR_COLON) begin
                            n_outcome = ST_INVALID;
                        end
                    end else if (r_pos <= POS_KIND_LAST) begin
                        if (!dig_ok) begin
                            n_outcome = ST_INVALID;
                        end else if (r_pos <= POS_COUNT_LAST) begin
                            n_count = {r_count[3:0], dig_val};
                        end else if (r_pos <= POS_ADDR_LAST) begin
                            if (r_pos == POS_ADDR_LAST) begin
                                n_addr = {1'b0, addr_shift} + {1'b0, i_cfg.addr_bias};
                            end else begin
                                n_addr = {1'b0, addr_shift};
                            end
                        end else begin
                            n_kind = {r_kind[3:0], dig_val};
                            if (r_pos == POS_KIND_LAST && n_kind == 8'd0 &&
                                addr_end >= {2'b00, i_cfg.mem_size}) begin
                                n_outcome = ST_OVERFLOW;
                            end
                        end
                    end else if (r_kind == 8'd0 && r_index < r_count) begin
                        if (!dig_ok) begin
                            n_outcome = ST_INVALID;
                        end else if (r_pos[0]) begin
                            // Odd positions carry the high digit of a data byte.
                            n_high = dig_val;
                        end else begin
                            res.write_valid = 1'b1;
                            res.write_data  = {r_high, dig_val};
                            res.write_addr  = ADDR_W'(r_addr) - ADDR_W'(i_cfg.mem_base)
                                            + ADDR_W'(r_index);
                            n_index = r_index + 8'd1;
                        end
                    end
                end
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
            end
            default: ;
        endcase
        res.stopped = n_halted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_addr    <= '0;
            r_kind    <= '0;
            r_high    <= '0;
            r_index   <= '0;
            r_outcome <= ST_NONE;
            r_halted  <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_kind    <= n_kind;
            r_high    <= n_high;
            r_index   <= n_index;
            r_outcome <= n_outcome;
            r_halted  <= n_halted;
        end
    end

    assign o_result = res;

endmodule

// File: src/intel_hex_record_loader.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// i_item    in   valid/ready            action, char_code
// o_result  out  valid/ready            write_valid, write_addr, write_data,
//                                       line_status, stopped
// i_cfg_*   in   write enable only      register index, 16-bit data
//
// One item per cycle sustained while o_result is ready; every item gives one result item.
// An accepted item is held in the input register and parsed from there; its
// result is registered in the output register, from which o_result hands it over.
// The input register refills while the result register drains, so a stall
// on o_result backs up through i_item.ready only once both hold an item.
// Synchronous active-low reset clears the parser, the valid flags and the
// configuration registers (mem_size resets to all ones).

module intel_hex_record_loader (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ihl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ihl_pkg::CFG_W-1:0]     i_cfg_data,
    ihl_in_if.sink                        i_item,
    ihl_out_if.source                     o_result
);
    import ihl_pkg::*;

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_result  r_out;

    t_cfg     cfg;
    t_result  step_res;
    logic     advance;

    ihl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ihl_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_item.action    <= i_item.action;
            r_in_item.char_code <= i_item.char_code;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.write_valid = r_out.write_valid;
    assign o_result.write_addr  = r_out.write_addr;
    assign o_result.write_data  = r_out.write_data;
    assign o_result.line_status = r_out.line_status;
    assign o_result.stopped     = r_out.stopped;

endmodule
